FILE: rtl/lkr_pkg.sv
// shared types, constants and codes for the lru-k frame replacer
`default_nettype none
package lkr_pkg;

  localparam int FRAME_COUNT = 64;
  localparam int ID_W       = 6;
  localparam int CNT_W      = 4;
  localparam int LIMIT_W    = 7;
  localparam int TOTAL_W    = 7;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0]   CNT_MAX    = 4'd15;
  localparam logic [CNT_W-1:0]   K_MIN      = 4'd2;
  localparam logic [CNT_W-1:0]   K_RESET    = 4'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX  = LIMIT_W'(FRAME_COUNT);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = TOTAL_W'(FRAME_COUNT);

  // commands
  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_EVICT  = 2'd3;

  // result status
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_PINNED = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_K   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 1'd1;

  // one list slot
  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic             ev;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  // control broadcast to every cell of one list
  typedef struct packed {
    logic            search;
    logic            find_ev;
    logic [ID_W-1:0] key;
    logic            drop;
    logic            push;
    logic            set_ev;
    logic            set_cnt;
    entry_t          fill;
  } lst_ctl_t;

  // what a list reports after a search
  typedef struct packed {
    logic   hit;
    entry_t pick;
  } lst_stat_t;

endpackage
`default_nettype wire

FILE: rtl/lkr_if.sv
// request and result channel interfaces of the lru-k frame replacer
`default_nettype none
interface lkr_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic [lkr_pkg::ID_W-1:0] frame_no;
  logic                     evictable_flag;

  modport source (output valid, output cmd, output frame_no, output evictable_flag,
                  input ready);
  modport sink (input valid, input cmd, input frame_no, input evictable_flag,
                output ready);
endinterface

interface lkr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic                        victim_valid;
  logic [lkr_pkg::ID_W-1:0]    victim_frame;
  logic [lkr_pkg::TOTAL_W-1:0] evictable_count;

  modport source (output valid, output status, output victim_valid, output victim_frame,
                  output evictable_count, input ready);
  modport sink (input valid, input status, input victim_valid, input victim_frame,
                input evictable_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/lkr_cell.sv
// one slot of an ordered frame list: match, first-evictable search and compaction
`default_nettype none
module lkr_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lkr_pkg::lst_ctl_t ctl,
  input  wire logic              prev_valid,
  input  wire logic              prev_found,
  input  wire lkr_pkg::entry_t   next_ent,
  output logic                   found,
  output lkr_pkg::entry_t        ent,
  output logic                   sel
);

  logic cand;
  logic after;

  always_comb begin
    if (ctl.find_ev) begin
      cand = ent.valid & ent.ev;
    end else begin
      cand = ent.valid & (ent.id == ctl.key);
    end
    found = prev_found | cand;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent   <= '0;
      sel   <= 1'b0;
      after <= 1'b0;
    end else begin
      if (ctl.search) begin
        sel   <= cand & ~prev_found;
        after <= found;
      end
      if (ctl.drop && after) begin
        // slots from the dropped one on move up; the old last slot takes a pushed entry
        if (ctl.push && ent.valid && !next_ent.valid) begin
          ent <= ctl.fill;
        end else begin
          ent <= next_ent;
        end
      end else if (ctl.push && !ent.valid && prev_valid) begin
        ent <= ctl.fill;
      end else if (sel) begin
        if (ctl.set_ev) begin
          ent.ev <= ctl.fill.ev;
        end
        if (ctl.set_cnt) begin
          ent.cnt <= ctl.fill.cnt;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lkr_list.sv
// ordered frame list built as a row of cells
`default_nettype none
module lkr_list (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lkr_pkg::lst_ctl_t ctl,
  output lkr_pkg::lst_stat_t     stat
);

  lkr_pkg::entry_t ents [lkr_pkg::FRAME_COUNT];
  logic [lkr_pkg::FRAME_COUNT-1:0] found;
  logic [lkr_pkg::FRAME_COUNT-1:0] sel;

  for (genvar i = 0; i < lkr_pkg::FRAME_COUNT; i++) begin : g_cell
    logic            prev_valid;
    logic            prev_found;
    lkr_pkg::entry_t next_ent;

    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
      assign prev_found = 1'b0;
    end else begin : g_mid
      assign prev_valid = ents[i-1].valid;
      assign prev_found = found[i-1];
    end

    if (i == lkr_pkg::FRAME_COUNT - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ents[i+1];
    end

    lkr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_valid (prev_valid),
      .prev_found (prev_found),
      .next_ent   (next_ent),
      .found      (found[i]),
      .ent        (ents[i]),
      .sel        (sel[i])
    );
  end

  // at most one cell is selected, so an or of the masked entries picks it
  always_comb begin
    stat.hit  = |sel;
    stat.pick = '0;
    for (int i = 0; i < lkr_pkg::FRAME_COUNT; i++) begin
      stat.pick = stat.pick | (sel[i] ? ents[i] : '0);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lru_k_frame_replacer_core.sv
// top level of the lru-k frame replacer
// Tracks up to 64 frames for LRU-K replacement in two rows of list cells, a history
// row ordered by first access and a recent row ordered by latest access. When a
// command is transferred every cell compares itself against the frame id (or, for
// evict, the rows find their first evictable cell through the neighbor chain); in
// the update state the rows compact, append or update in place and the result is
// loaded into the output register. The request side takes a new command once that
// result is loaded; a held result stalls only the update state. The user must write
// history_k and frame_limit through the cfg port while idle; the block does not enforce it.
`default_nettype none
module lru_k_frame_replacer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lkr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lkr_pkg::CFG_W-1:0]       cfg_data,
  lkr_req_if.sink                              req,
  lkr_rsp_if.source                            rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic state;
  logic [lkr_pkg::CNT_W-1:0]   history_k;
  logic [lkr_pkg::LIMIT_W-1:0] frame_limit;
  logic [lkr_pkg::TOTAL_W-1:0] evictable_total;
  logic [lkr_pkg::TOTAL_W-1:0] evictable_total_next;

  logic [1:0]                cmd_q;
  logic [lkr_pkg::ID_W-1:0]  id_q;
  logic                      flag_q;

  lkr_pkg::lst_ctl_t  hctl;
  lkr_pkg::lst_ctl_t  rctl;
  lkr_pkg::lst_stat_t hs;
  lkr_pkg::lst_stat_t rs;

  logic                        accept;
  logic                        upd_go;
  logic [lkr_pkg::CNT_W-1:0]   k_eff;
  logic [lkr_pkg::LIMIT_W-1:0] limit_eff;
  logic                        present;
  lkr_pkg::entry_t             cur;
  logic [lkr_pkg::CNT_W-1:0]   cnt_inc;
  logic [1:0]                  status_next;
  logic                        vvalid_next;
  logic [lkr_pkg::ID_W-1:0]    vframe_next;
  logic                        upd_h;
  logic                        upd_r;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid & req.ready;
  assign upd_go    = (state == ST_UPD) & (~rsp.valid | rsp.ready);

  assign k_eff     = (history_k < lkr_pkg::K_MIN) ? lkr_pkg::K_MIN : history_k;
  assign limit_eff = (frame_limit > lkr_pkg::LIMIT_MAX) ? lkr_pkg::LIMIT_MAX : frame_limit;
  assign present   = hs.hit | rs.hit;
  assign cur       = hs.hit ? hs.pick : rs.pick;
  assign cnt_inc   = (cur.cnt == lkr_pkg::CNT_MAX) ? lkr_pkg::CNT_MAX
                                                   : cur.cnt + lkr_pkg::CNT_W'(1);

  always_comb begin
    hctl = '0;
    rctl = '0;
    hctl.search  = accept;
    rctl.search  = accept;
    hctl.find_ev = (req.cmd == lkr_pkg::CMD_EVICT);
    rctl.find_ev = (req.cmd == lkr_pkg::CMD_EVICT);
    hctl.key     = req.frame_no;
    rctl.key     = req.frame_no;
    upd_h        = 1'b0;
    upd_r        = 1'b0;
    status_next  = lkr_pkg::ST_OK;
    vvalid_next  = 1'b0;
    vframe_next  = '0;
    evictable_total_next = evictable_total;

    if (cmd_q != lkr_pkg::CMD_EVICT && {1'b0, id_q} >= limit_eff) begin
      status_next = lkr_pkg::ST_RANGE;
    end else begin
      case (cmd_q)
        lkr_pkg::CMD_RECORD: begin
          if (!present) begin
            hctl.push = 1'b1;
            hctl.fill = '{valid: 1'b1, id: id_q, ev: 1'b0, cnt: lkr_pkg::CNT_W'(1)};
          end else if (hs.hit) begin
            if (cnt_inc >= k_eff) begin
              hctl.drop = 1'b1;
              rctl.push = 1'b1;
              rctl.fill = '{valid: 1'b1, id: id_q, ev: cur.ev, cnt: cnt_inc};
            end else begin
              hctl.set_cnt  = 1'b1;
              hctl.fill.cnt = cnt_inc;
            end
          end else begin
            // move to the tail of the recent row
            rctl.drop = 1'b1;
            rctl.push = 1'b1;
            rctl.fill = '{valid: 1'b1, id: id_q, ev: cur.ev, cnt: cnt_inc};
          end
        end
        lkr_pkg::CMD_SET: begin
          if (present) begin
            upd_h = hs.hit;
            upd_r = ~hs.hit;
            hctl.set_ev  = upd_h;
            rctl.set_ev  = upd_r;
            hctl.fill.ev = flag_q;
            rctl.fill.ev = flag_q;
            if (flag_q && !cur.ev) begin
              evictable_total_next = evictable_total + lkr_pkg::TOTAL_W'(1);
            end else if (!flag_q && cur.ev && evictable_total != '0) begin
              evictable_total_next = evictable_total - lkr_pkg::TOTAL_W'(1);
            end
          end
        end
        lkr_pkg::CMD_REMOVE: begin
          if (present) begin
            if (!cur.ev) begin
              status_next = lkr_pkg::ST_PINNED;
            end else begin
              hctl.drop = hs.hit;
              rctl.drop = ~hs.hit;
              if (evictable_total != '0) begin
                evictable_total_next = evictable_total - lkr_pkg::TOTAL_W'(1);
              end
            end
          end
        end
        lkr_pkg::CMD_EVICT: begin
          if (present) begin
            hctl.drop   = hs.hit;
            rctl.drop   = ~hs.hit;
            vvalid_next = 1'b1;
            vframe_next = cur.id;
            if (evictable_total != '0) begin
              evictable_total_next = evictable_total - lkr_pkg::TOTAL_W'(1);
            end
          end else begin
            status_next = lkr_pkg::ST_EMPTY;
          end
        end
        default: begin
          status_next = lkr_pkg::ST_OK;
        end
      endcase
    end

    // list changes happen only in the cycle the result is loaded
    if (!upd_go) begin
      hctl.drop    = 1'b0;
      hctl.push    = 1'b0;
      hctl.set_ev  = 1'b0;
      hctl.set_cnt = 1'b0;
      rctl.drop    = 1'b0;
      rctl.push    = 1'b0;
      rctl.set_ev  = 1'b0;
      rctl.set_cnt = 1'b0;
    end
  end

  lkr_list u_history (
    .clk  (clk),
    .rst  (rst),
    .ctl  (hctl),
    .stat (hs)
  );

  lkr_list u_recent (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rctl),
    .stat (rs)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      history_k       <= lkr_pkg::K_RESET;
      frame_limit     <= lkr_pkg::LIMIT_MAX;
      evictable_total <= '0;
      rsp.valid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lkr_pkg::REG_HISTORY_K:   history_k   <= cfg_data[lkr_pkg::CNT_W-1:0];
          lkr_pkg::REG_FRAME_LIMIT: frame_limit <= cfg_data[lkr_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (upd_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (upd_go) begin
        evictable_total <= evictable_total_next;
        rsp.valid       <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= req.cmd;
      id_q   <= req.frame_no;
      flag_q <= req.evictable_flag;
    end
    if (upd_go) begin
      rsp.status          <= status_next;
      rsp.victim_valid    <= vvalid_next;
      rsp.victim_frame    <= vframe_next;
      rsp.evictable_count <= evictable_total_next;
    end
  end

`ifndef SYNTH
  // a tracked frame sits in exactly one of the two rows
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && cmd_q != lkr_pkg::CMD_EVICT) |-> !(hs.hit && rs.hit))
    else $error("frame found in both history and recent rows");

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    evictable_total <= lkr_pkg::TOTAL_MAX)
    else $error("evictable total exceeds frame count");

  a_rsp_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_UPD)
    else $error("result raised without an update cycle");

  a_victim_evictable: assert property (@(posedge clk) disable iff (rst)
    (upd_go && cmd_q == lkr_pkg::CMD_EVICT && present) |-> cur.ev)
    else $error("evict picked a pinned frame");
`endif

endmodule
`default_nettype wire
